/* rtl/tbrd_pkg.sv */
// ----------------------------------------------------------------------------
// Typed block ring deque package
// Action, block kind and status codes, controller states and the result beat.
// ----------------------------------------------------------------------------
package tbrd_pkg;

  localparam int HANDLE_W = 16;
  localparam int LEVEL_W  = 5;

  typedef enum logic [2:0] {
    ACT_ENQUEUE    = 3'd0,
    ACT_DEQUEUE    = 3'd1,
    ACT_PUSH_FRONT = 3'd2,
    ACT_PEEK       = 3'd3,
    ACT_DISCARD    = 3'd4,
    ACT_STRIP_CTRL = 3'd5,
    ACT_STRIP_INFO = 3'd6,
    ACT_CLEAR      = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    KIND_INFO    = 2'd0,
    KIND_RR      = 2'd1,
    KIND_SUP     = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

  typedef struct packed {
    status_t               status;
    kind_t                 kind;
    logic [HANDLE_W-1:0]   handle;
    logic [LEVEL_W-1:0]    fill_level;
    logic [LEVEL_W-1:0]    info_count;
    logic [LEVEL_W-1:0]    control_count;
  } result_t;

endpackage

/* rtl/tbrd_mem.sv */
// ----------------------------------------------------------------------------
// Typed block ring deque entry memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tbrd_mem #(
  parameter int DEPTH = 16,
  parameter int EW    = 18
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [EW-1:0]            wdata,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [EW-1:0]            rdata
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/tbrd_engine.sv */
// ----------------------------------------------------------------------------
// Typed block ring deque engine
// Pointers, counters and the sequencer that reads the bottom entry, acts on
// it and writes back; strip actions iterate one entry per read.
// ----------------------------------------------------------------------------
module tbrd_engine #(
  parameter int DEPTH       = 16,
  parameter int HANDLE_BITS = 16,
  localparam int PW = $clog2(DEPTH),
  localparam int SB = (HANDLE_BITS < 16) ? HANDLE_BITS : 16,
  localparam int EW = SB + 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tbrd_pkg::action_t                   in_action,
  input  tbrd_pkg::kind_t                     in_kind,
  input  logic [tbrd_pkg::HANDLE_W-1:0]       in_handle,
  input  logic                                out_free,
  output logic                                commit,
  output tbrd_pkg::result_t                   result,
  output logic                                mem_wr_en,
  output logic [PW-1:0]                       mem_waddr,
  output logic [EW-1:0]                       mem_wdata,
  output logic                                mem_rd_en,
  output logic [PW-1:0]                       mem_raddr,
  input  logic [EW-1:0]                       mem_rdata
);
  import tbrd_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  state_t         state_r, state_nxt;
  action_t        act_r, act_nxt;
  kind_t          kind_r, kind_nxt;
  logic [SB-1:0]  handle_r, handle_nxt;
  logic [PW-1:0]  bot_r, bot_nxt;
  logic [PW-1:0]  top_r, top_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  info_r, info_nxt;
  logic [CW-1:0]  done_r, done_nxt;
  logic [CW-1:0]  total_r, total_nxt;

  logic           fin;
  logic           empty, full;
  kind_t          rk;
  logic [SB-1:0]  rh;
  status_t        res_status;
  kind_t          res_kind;
  logic [SB-1:0]  res_handle;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
  endfunction

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(DEPTH));
  assign rk    = kind_t'(mem_rdata[EW-1:SB]);
  assign rh    = mem_rdata[SB-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!fin) state_nxt = S_READ;
        else if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The bottom entry is read while idle so that it is ready when an item
  // arrives, and again before each further step of a strip.
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    mem_rd_en = (state_r == S_IDLE) || (state_r == S_READ);
    mem_raddr = bot_r;
  end

  // Datapath.
  always_comb begin
    act_nxt    = act_r;
    kind_nxt   = kind_r;
    handle_nxt = handle_r;
    bot_nxt    = bot_r;
    top_nxt    = top_r;
    cnt_nxt    = cnt_r;
    info_nxt   = info_r;
    done_nxt   = done_r;
    total_nxt  = total_r;
    mem_wr_en  = 1'b0;
    mem_waddr  = top_r;
    mem_wdata  = {kind_r, handle_r};
    fin        = 1'b0;
    res_status = ST_OK;
    res_kind   = KIND_INFO;
    res_handle = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt    = in_action;
          kind_nxt   = in_kind;
          handle_nxt = SB'(in_handle);
          total_nxt  = cnt_r;
          done_nxt   = '0;
        end
      end
      S_EXEC: begin
        case (act_r)
          ACT_ENQUEUE: begin
            fin = 1'b1;
            if (full) begin
              res_status = ST_FULL;
            end else begin
              mem_wr_en = 1'b1;
              mem_waddr = top_r;
              top_nxt   = ptr_inc(top_r);
              cnt_nxt   = cnt_r + 1'b1;
              if (kind_r == KIND_INFO && info_r < CW'(DEPTH)) info_nxt = info_r + 1'b1;
            end
          end
          ACT_PUSH_FRONT: begin
            fin = 1'b1;
            if (full) begin
              res_status = ST_FULL;
            end else begin
              mem_wr_en = 1'b1;
              mem_waddr = ptr_dec(bot_r);
              bot_nxt   = ptr_dec(bot_r);
              cnt_nxt   = cnt_r + 1'b1;
              if (kind_r == KIND_INFO && info_r < CW'(DEPTH)) info_nxt = info_r + 1'b1;
            end
          end
          ACT_DEQUEUE, ACT_PEEK, ACT_DISCARD: begin
            fin = 1'b1;
            if (empty) begin
              res_status = ST_EMPTY;
            end else begin
              if (act_r != ACT_DISCARD) begin
                res_kind   = rk;
                res_handle = rh;
              end
              if (act_r != ACT_PEEK) begin
                bot_nxt = ptr_inc(bot_r);
                cnt_nxt = cnt_r - 1'b1;
                if (rk == KIND_INFO && info_r != '0) info_nxt = info_r - 1'b1;
              end
            end
          end
          ACT_STRIP_CTRL: begin
            // An information block at the bottom ends the strip in place.
            if (empty || rk == KIND_INFO) begin
              fin = 1'b1;
            end else begin
              bot_nxt = ptr_inc(bot_r);
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          ACT_STRIP_INFO: begin
            if (empty || done_r >= total_r) begin
              fin = 1'b1;
            end else begin
              case (rk)
                KIND_RR, KIND_SUP: begin
                  // Rotate the control block from the bottom to the top.
                  mem_wr_en = 1'b1;
                  mem_waddr = top_r;
                  mem_wdata = mem_rdata;
                  top_nxt   = ptr_inc(top_r);
                  bot_nxt   = ptr_inc(bot_r);
                  done_nxt  = done_r + 1'b1;
                end
                KIND_INFO: begin
                  bot_nxt  = ptr_inc(bot_r);
                  cnt_nxt  = cnt_r - 1'b1;
                  done_nxt = done_r + 1'b1;
                  if (info_r != '0) info_nxt = info_r - 1'b1;
                end
                default: begin
                  fin        = 1'b1;
                  res_status = ST_INVALID;
                end
              endcase
            end
          end
          ACT_CLEAR: begin
            fin      = 1'b1;
            bot_nxt  = '0;
            top_nxt  = '0;
            cnt_nxt  = '0;
            info_nxt = '0;
          end
          default: begin
            fin = 1'b1;
          end
        endcase

        // A final step waits, with no side effect, until the output is free.
        if (fin && !out_free) begin
          bot_nxt   = bot_r;
          top_nxt   = top_r;
          cnt_nxt   = cnt_r;
          info_nxt  = info_r;
          mem_wr_en = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    commit               = (state_r == S_EXEC) && fin && out_free;
    result.status        = res_status;
    result.kind          = res_kind;
    result.handle        = HANDLE_W'(res_handle);
    result.fill_level    = LEVEL_W'(cnt_nxt);
    result.info_count    = LEVEL_W'(info_nxt);
    result.control_count = (cnt_nxt > info_nxt) ? LEVEL_W'(cnt_nxt - info_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bot_r   <= '0;
      top_r   <= '0;
      cnt_r   <= '0;
      info_r  <= '0;
      done_r  <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      bot_r   <= bot_nxt;
      top_r   <= top_nxt;
      cnt_r   <= cnt_nxt;
      info_r  <= info_nxt;
      done_r  <= done_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    kind_r   <= kind_nxt;
    handle_r <= handle_nxt;
  end

endmodule

/* rtl/typed_block_ring_deque.sv */
// ----------------------------------------------------------------------------
// Typed block ring deque
// Ring-buffer deque of typed block descriptors with bulk strip actions.
// ----------------------------------------------------------------------------
// A single-entry action is registered on acceptance and run in the exec state,
// which waits for a free output register; no new item is taken until idle.
// Strip actions visit one entry per step, since each step waits on one
// registered read of the entry memory.
// Synchronous active-low reset empties the deque; memory contents are kept.
module typed_block_ring_deque #(
  parameter int DEPTH       = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] block_handle
  input  logic [4:0]  in_tuser,   // [2:0] action, [4:3] block_kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] out_handle, [20:16] fill_level,
                                  // [25:21] info_count, [30:26] control_count
  output logic [3:0]  out_tuser   // [1:0] status, [3:2] out_kind
);
  import tbrd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int SB = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
  localparam int EW = SB + 2;

  logic          out_free;
  logic          commit;
  result_t       result;
  logic          mem_wr_en, mem_rd_en;
  logic [PW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;
  logic          out_valid_r;
  result_t       out_res_r;

  tbrd_engine #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (action_t'(in_tuser[2:0])),
    .in_kind   (kind_t'(in_tuser[4:3])),
    .in_handle (in_tdata),
    .out_free  (out_free),
    .commit    (commit),
    .result    (result),
    .mem_wr_en (mem_wr_en),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_rd_en (mem_rd_en),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tbrd_mem #(
    .DEPTH (DEPTH),
    .EW    (EW)
  ) u_mem (
    .clk   (clk),
    .wr_en (mem_wr_en),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .rd_en (mem_rd_en),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.control_count, out_res_r.info_count,
                       out_res_r.fill_level, out_res_r.handle};
  assign out_tuser  = {out_res_r.kind, out_res_r.status};

  // A result is only loaded when the output register is free to take it.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (!out_valid_r || out_tready))
    else $error("result committed over an unread beat");

  // The engine never completes an item while it is waiting for a new one.
  a_idle_no_commit: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !commit)
    else $error("commit while idle");

  // After an item completes, the engine is ready for the next one.
  a_commit_then_ready: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> in_tready)
    else $error("engine not idle after commit");

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Typed block ring deque testbench
// Drives action beats into the deque and checks every result beat against an
// in-bench model of the ring buffer. A directed sweep of the empty and full
// cases and the strip actions comes first, followed by randomly biased fill
// and drain phases. Random back-pressure and gaps are applied on both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbrd_pkg::*;

  localparam int DEPTH      = 16;
  localparam int RANDOM_OPS = 1900;
  localparam int END_WAIT   = 2 * DEPTH + 10;
  localparam int IDLE_PCT   = 7;

  typedef struct {
    action_t             act;
    kind_t               kind;
    logic [HANDLE_W-1:0] handle;
    bit                  wait_drain;
  } deque_op_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;  // [15:0] block_handle
  logic [4:0]  in_tuser   = '0;  // [2:0] action, [4:3] block_kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [15:0] out_handle, [20:16] fill_level,
                                 // [25:21] info_count, [30:26] control_count
  logic [3:0]  out_tuser;        // [1:0] status, [3:2] out_kind

  typed_block_ring_deque #(
    .DEPTH      (DEPTH),
    .HANDLE_BITS(HANDLE_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  deque_op_t op_queue[$];
  result_t   due_results[$];
  deque_op_t cur_op;
  int        n_results = 0;
  int        n_errors  = 0;
  logic      hold_off  = 1'b0;
  logic      calm;

  // A stretch of results during which neither side idles.
  assign calm = (n_results >= 700) && (n_results < 1000);

  // Model of the deque contents.
  kind_t               slot_kind   [DEPTH];
  logic [HANDLE_W-1:0] slot_handle [DEPTH];
  int                  bot_idx   = 0;
  int                  top_idx   = 0;
  int                  held      = 0;
  int                  held_info = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic status_t put_top_slot(kind_t k, logic [HANDLE_W-1:0] h);
    if (held >= DEPTH) begin
      return ST_FULL;
    end
    slot_kind[top_idx]   = k;
    slot_handle[top_idx] = h;
    top_idx = (top_idx + 1) % DEPTH;
    held++;
    if (k == KIND_INFO && held_info < DEPTH) begin
      held_info++;
    end
    return ST_OK;
  endfunction

  function automatic void drop_bottom_slot();
    if (slot_kind[bot_idx] == KIND_INFO && held_info > 0) begin
      held_info--;
    end
    bot_idx = (bot_idx + 1) % DEPTH;
    held--;
  endfunction

  function automatic result_t apply_deque_action(deque_op_t op);
    result_t             r;
    int                  total;
    int                  seen;
    kind_t               k;
    logic [HANDLE_W-1:0] h;
    r = '0;
    case (op.act)
      ACT_ENQUEUE: begin
        r.status = put_top_slot(op.kind, op.handle);
      end
      ACT_DEQUEUE, ACT_PEEK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.kind   = slot_kind[bot_idx];
          r.handle = slot_handle[bot_idx];
          if (op.act == ACT_DEQUEUE) begin
            drop_bottom_slot();
          end
        end
      end
      ACT_PUSH_FRONT: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          bot_idx = (bot_idx + DEPTH - 1) % DEPTH;
          slot_kind[bot_idx]   = op.kind;
          slot_handle[bot_idx] = op.handle;
          held++;
          if (op.kind == KIND_INFO && held_info < DEPTH) begin
            held_info++;
          end
        end
      end
      ACT_DISCARD: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          drop_bottom_slot();
        end
      end
      ACT_STRIP_CTRL: begin
        // Invalid blocks go the same way as control blocks.
        while (held > 0 && slot_kind[bot_idx] != KIND_INFO) begin
          drop_bottom_slot();
        end
      end
      ACT_STRIP_INFO: begin
        total = held;
        seen  = 0;
        while (held > 0 && seen < total && r.status == ST_OK) begin
          k = slot_kind[bot_idx];
          h = slot_handle[bot_idx];
          if (k == KIND_INVALID) begin
            r.status = ST_INVALID;
          end else begin
            drop_bottom_slot();
            if (k != KIND_INFO) begin
              void'(put_top_slot(k, h));
            end
            seen++;
          end
        end
      end
      default: begin
        bot_idx   = 0;
        top_idx   = 0;
        held      = 0;
        held_info = 0;
      end
    endcase
    r.fill_level    = LEVEL_W'(held);
    r.info_count    = LEVEL_W'(held_info);
    r.control_count = (held > held_info) ? LEVEL_W'(held - held_info) : '0;
    return r;
  endfunction

  task automatic note_mismatch(string field, int got, int want);
    $display("ERROR: result %0d: %s is 0x%0h, expected 0x%0h", n_results, field, got, want);
    n_errors++;
  endtask

  task automatic queue_op(action_t a, kind_t k, logic [HANDLE_W-1:0] h, bit drain);
    deque_op_t op;
    op.act        = a;
    op.kind       = k;
    op.handle     = h;
    op.wait_drain = drain;
    op_queue.push_back(op);
  endtask

  // Sender: the model is advanced on each accepted input beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(apply_deque_action(cur_op));
      end
      if (!in_tvalid || in_tready) begin
        if (op_queue.size() > 0 && !(op_queue[0].wait_drain && due_results.size() > 0) &&
            (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_op = op_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= cur_op.handle;
          in_tuser  <= {cur_op.kind, cur_op.act};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares each result beat with the oldest one due.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        note_mismatch("beat with nothing due", int'(out_tdata), 0);
      end else begin
        want = due_results.pop_front();
        if (out_tuser[1:0] !== want.status) begin
          note_mismatch("status", int'(out_tuser[1:0]), int'(want.status));
        end
        if (out_tuser[3:2] !== want.kind) begin
          note_mismatch("out_kind", int'(out_tuser[3:2]), int'(want.kind));
        end
        if (out_tdata[15:0] !== want.handle) begin
          note_mismatch("out_handle", int'(out_tdata[15:0]), int'(want.handle));
        end
        if (out_tdata[20:16] !== want.fill_level) begin
          note_mismatch("fill_level", int'(out_tdata[20:16]), int'(want.fill_level));
        end
        if (out_tdata[25:21] !== want.info_count) begin
          note_mismatch("info_count", int'(out_tdata[25:21]), int'(want.info_count));
        end
        if (out_tdata[30:26] !== want.control_count) begin
          note_mismatch("control_count", int'(out_tdata[30:26]),
                        int'(want.control_count));
        end
      end
      n_results++;
    end
    out_tready <= rst_n && !hold_off && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  // Long receiver stall so that the deque backs up and stops taking input.
  initial begin
    while (n_results < 1300) begin
      @(negedge clk);
    end
    hold_off = 1'b1;
    repeat (400) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int    add_pct;
    int    roll;
    kind_t k;
    // Operations on the empty deque; the block fields are don't-care here.
    queue_op(ACT_DEQUEUE, KIND_INVALID, 16'hFFFF, 1'b0);
    queue_op(ACT_PEEK, KIND_SUP, 16'hFFFF, 1'b0);
    queue_op(ACT_DISCARD, KIND_RR, 16'h0000, 1'b0);
    queue_op(ACT_STRIP_CTRL, KIND_INFO, 16'h5555, 1'b0);
    queue_op(ACT_STRIP_INFO, KIND_INFO, 16'hAAAA, 1'b0);
    // Fill to the brim from both ends, with one invalid block in the middle.
    queue_op(ACT_PUSH_FRONT, KIND_INFO, 16'hFFFF, 1'b0);
    for (int i = 0; i < 14; i++) begin
      k = (i == 8) ? KIND_INVALID : kind_t'(i % 3);
      queue_op(ACT_ENQUEUE, k, (i == 0) ? 16'h0000 : 16'(1 << i), 1'b0);
    end
    queue_op(ACT_PUSH_FRONT, KIND_RR, 16'h8000, 1'b0);
    queue_op(ACT_ENQUEUE, KIND_INFO, 16'h1234, 1'b0);
    queue_op(ACT_PUSH_FRONT, KIND_SUP, 16'h4321, 1'b0);
    queue_op(ACT_PEEK, KIND_INFO, 16'h0000, 1'b0);
    queue_op(ACT_DEQUEUE, KIND_INFO, 16'h0000, 1'b0);
    queue_op(ACT_STRIP_INFO, KIND_INFO, 16'h0000, 1'b0);
    queue_op(ACT_STRIP_CTRL, KIND_INFO, 16'h0000, 1'b0);
    queue_op(ACT_CLEAR, KIND_INVALID, 16'hFFFF, 1'b0);

    // Random phases that lean toward filling, draining or neither.
    add_pct = 45;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(2))
          0:       add_pct = 75;
          1:       add_pct = 20;
          default: add_pct = 45;
        endcase
      end
      roll = $urandom_range(99);
      k = ($urandom_range(9) == 0) ? KIND_INVALID : kind_t'($urandom_range(2));
      if (roll < add_pct) begin
        queue_op($urandom_range(1) ? ACT_ENQUEUE : ACT_PUSH_FRONT, k, 16'($urandom),
                 i == 0 || i == 600 || i == 1500);
      end else begin
        roll = $urandom_range(99);
        queue_op((roll < 40) ? ACT_DEQUEUE :
                 (roll < 55) ? ACT_PEEK :
                 (roll < 72) ? ACT_DISCARD :
                 (roll < 85) ? ACT_STRIP_CTRL :
                 (roll < 97) ? ACT_STRIP_INFO : ACT_CLEAR,
                 kind_t'($urandom_range(3)), 16'($urandom),
                 i == 0 || i == 600 || i == 1500);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() > 0 || in_tvalid) begin
      @(negedge clk);
    end
    while (due_results.size() > 0) begin
      @(negedge clk);
    end
    repeat (END_WAIT) @(negedge clk);
    if (n_errors == 0 && due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
